@@ rtl/hilbert_2d_index_to_address_unit_macros.svh @@
// Assertion macros for the Hilbert index-to-address unit.
// Included by the RTL file that carries concurrent checks; expects clock and reset in scope.
`ifndef HILBERT_2D_INDEX_TO_ADDRESS_UNIT_MACROS_SVH
`define HILBERT_2D_INDEX_TO_ADDRESS_UNIT_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define HIL_ASSERT_IMP(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("hilbert unit check failed");

// Next-cycle implication, disabled while in reset.
`define HIL_ASSERT_NXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("hilbert unit check failed");

`endif

@@ rtl/hil2d_pkg.sv @@
// Shared types and constants for the Hilbert index-to-address unit.
// No dependencies.
package hil2d_pkg;

   localparam int POS_W    = 24;
   localparam int COORD_W  = 12;
   localparam int ADDR_W   = 28;
   localparam int ORDER_W  = 5;   // effective order, holds up to 31
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;
   localparam int STRIDE_W   = 16;
   localparam int CORD_REG_W = 4;

   localparam logic [CSR_IDX_W-1:0] CSR_CURVE_ORDER = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ROW_STRIDE  = 2'd1;

   localparam logic [CORD_REG_W-1:0] CURVE_ORDER_RESET = 4'd4;
   localparam logic [STRIDE_W-1:0]   ROW_STRIDE_RESET  = 16'd16;

   // Side data carried down the cell chain with each transaction.
   typedef struct packed {
      logic [POS_W-1:0] pos;
      logic             oor;
   } hil2d_meta_type;

endpackage

@@ rtl/hil2d_cell.sv @@
// One recursion level of the Hilbert d2xy walk as a registered pipeline cell.
// Depends on hil2d_pkg.
module hil2d_cell
   import hil2d_pkg::*;
#(
   parameter int LEVEL = 0,
   parameter int CW    = 12
) (
   input  logic                clock,
   input  logic                reset,
   input  logic [ORDER_W-1:0]  order_eff,
   input  logic                up_valid,
   output logic                up_ready,
   input  hil2d_meta_type      up_meta,
   input  logic [CW-1:0]       up_x,
   input  logic [CW-1:0]       up_y,
   output logic                dn_valid,
   input  logic                dn_ready,
   output hil2d_meta_type      dn_meta,
   output logic [CW-1:0]       dn_x,
   output logic [CW-1:0]       dn_y
);

   localparam logic [CW-1:0] LOW_MASK = CW'((1 << LEVEL) - 1);
   localparam logic [CW-1:0] LVL_BIT  = CW'(1) << LEVEL;

   logic           valid_ff;
   hil2d_meta_type meta_ff;
   logic [CW-1:0]  x_ff, y_ff, x_in, y_in;
   logic [1:0]     tb;
   logic           rx, ry, active;
   logic [CW-1:0]  xa, ya;

   assign active = ORDER_W'(LEVEL) < order_eff;

   always_comb begin
      tb = 2'(up_meta.pos >> (2 * LEVEL));
      rx = tb[1];
      ry = tb[0] ^ tb[1];
      xa = up_x;
      ya = up_y;
      if (rx) begin
         xa = up_x ^ LOW_MASK;
         ya = up_y ^ LOW_MASK;
      end
      if (active) begin
         if (!ry) begin
            x_in = ya;
            y_in = xa;
         end else begin
            x_in = up_x;
            y_in = up_y;
         end
         if (rx) x_in = x_in | LVL_BIT;
         if (ry) y_in = y_in | LVL_BIT;
      end else begin
         x_in = up_x;
         y_in = up_y;
      end
   end

   assign up_ready = !valid_ff || dn_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (up_ready) begin
         valid_ff <= up_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (up_ready) begin
         meta_ff <= up_meta;
         x_ff    <= x_in;
         y_ff    <= y_in;
      end
   end

   assign dn_valid = valid_ff;
   assign dn_meta  = meta_ff;
   assign dn_x     = x_ff;
   assign dn_y     = y_ff;

endmodule

@@ rtl/hil2d_addr_stage.sv @@
// Output stage: exchanges axes, forms x + stride*y and holds the result transaction.
// Depends on hil2d_pkg and the assertion macro header.
`include "hilbert_2d_index_to_address_unit_macros.svh"
module hil2d_addr_stage
   import hil2d_pkg::*;
#(
   parameter int CW = 12
) (
   input  logic                clock,
   input  logic                reset,
   input  logic [STRIDE_W-1:0] row_stride,
   input  logic                up_valid,
   output logic                up_ready,
   input  hil2d_meta_type      up_meta,
   input  logic [CW-1:0]       up_x,
   input  logic [CW-1:0]       up_y,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [POS_W-1:0]    rsp_position_echo,
   output logic [COORD_W-1:0]  rsp_x_coord,
   output logic [COORD_W-1:0]  rsp_y_coord,
   output logic [ADDR_W-1:0]   rsp_linear_address,
   output logic                rsp_out_of_range
);

   logic                valid_ff;
   logic [POS_W-1:0]    pos_ff;
   logic [COORD_W-1:0]  x_ff, y_ff, x_in, y_in;
   logic [ADDR_W-1:0]   addr_ff, addr_in;
   logic                oor_ff;

   // walk's second coordinate is the column, first is the row
   always_comb begin
      if (up_meta.oor) begin
         x_in    = '0;
         y_in    = '0;
         addr_in = '0;
      end else begin
         x_in    = COORD_W'(up_y);
         y_in    = COORD_W'(up_x);
         // operands widened first so the product keeps all 28 bits
         addr_in = ADDR_W'(row_stride) * ADDR_W'(y_in) + ADDR_W'(x_in);
      end
   end

   assign up_ready = !valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (up_ready) begin
         valid_ff <= up_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (up_ready) begin
         pos_ff  <= up_meta.pos;
         oor_ff  <= up_meta.oor;
         x_ff    <= x_in;
         y_ff    <= y_in;
         addr_ff <= addr_in;
      end
   end

   assign rsp_valid          = valid_ff;
   assign rsp_position_echo  = pos_ff;
   assign rsp_x_coord        = x_ff;
   assign rsp_y_coord        = y_ff;
   assign rsp_linear_address = addr_ff;
   assign rsp_out_of_range   = oor_ff;

   `HIL_ASSERT_IMP(a_oor_zero, rsp_valid && rsp_out_of_range,
      rsp_x_coord == '0 && rsp_y_coord == '0 && rsp_linear_address == '0)
   `HIL_ASSERT_IMP(a_addr_ge_x, rsp_valid, rsp_linear_address >= ADDR_W'(rsp_x_coord))
   `HIL_ASSERT_IMP(a_row0_addr, rsp_valid && rsp_y_coord == '0,
      rsp_linear_address == ADDR_W'(rsp_x_coord))

endmodule

@@ rtl/hilbert_2d_index_to_address_unit.sv @@
// Top level of the Hilbert index-to-address unit: CSRs, range check and the cell chain.
// Depends on hil2d_pkg, hil2d_cell and hil2d_addr_stage.

// Maps a position along a 2D Hilbert curve of order curve_order (grid side
// 2^order) to the visited cell's column, row and row-major address
// x + row_stride*y. Order 1 visits (0,0),(1,0),(1,1),(0,1). Positions at or
// beyond 4^order return out_of_range = 1 with all coordinates zero; orders
// above MAX_ORDER saturate to MAX_ORDER. Throughput is one transaction per
// clock unless the output stalls. The pipeline is a chain of MAX_ORDER cells,
// one per recursion level, each resolving two position bits and registering
// the partial coordinates, followed by one stage holding the 16x12 stride
// multiply, the address add and the result register. Each stage has its own
// valid bit and the ready chain lets bubbles close up, so a stalled result
// does not block transactions still moving through emptier stages.
// CSRs are a plain write port (index 0 = curve_order, 1 = row_stride, other
// indexes ignored) and should be written only while no transaction is in
// flight; the cells read the live order.
module hilbert_2d_index_to_address_unit
   import hil2d_pkg::*;
#(
   parameter int MAX_ORDER = 12
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_write_enable,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_write_data,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [POS_W-1:0]      req_position,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [POS_W-1:0]      rsp_position_echo,
   output logic [COORD_W-1:0]    rsp_x_coord,
   output logic [COORD_W-1:0]    rsp_y_coord,
   output logic [ADDR_W-1:0]     rsp_linear_address,
   output logic                  rsp_out_of_range
);

   localparam int CW = MAX_ORDER;   // internal coordinate width

   logic [CORD_REG_W-1:0] csr_curve_order_ff;
   logic [STRIDE_W-1:0]   csr_row_stride_ff;
   logic [ORDER_W-1:0]    ord_wide, order_eff;

   // CSR write port, no read-back
   always_ff @(posedge clock) begin
      if (reset) begin
         csr_curve_order_ff <= CURVE_ORDER_RESET;
         csr_row_stride_ff  <= ROW_STRIDE_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_CURVE_ORDER: csr_curve_order_ff <= CORD_REG_W'(csr_write_data);
            CSR_ROW_STRIDE:  csr_row_stride_ff  <= STRIDE_W'(csr_write_data);
            default: ;
         endcase
      end
   end

   // saturate order to the number of cells built
   assign ord_wide  = ORDER_W'(csr_curve_order_ff);
   assign order_eff = (ord_wide > ORDER_W'(MAX_ORDER)) ? ORDER_W'(MAX_ORDER) : ord_wide;

   // chain buses: index k feeds cell k, index MAX_ORDER feeds the output stage
   logic           ch_valid [MAX_ORDER+1];
   logic           ch_ready [MAX_ORDER+1];
   hil2d_meta_type ch_meta  [MAX_ORDER+1];
   logic [CW-1:0]  ch_x     [MAX_ORDER+1];
   logic [CW-1:0]  ch_y     [MAX_ORDER+1];

   // out of range when any bit at or above 2*order is set
   assign ch_valid[0]     = req_valid;
   assign req_ready       = ch_ready[0];
   assign ch_meta[0].pos  = req_position;
   assign ch_meta[0].oor  = (req_position >> {order_eff, 1'b0}) != '0;
   assign ch_x[0]         = '0;
   assign ch_y[0]         = '0;

   for (genvar k = 0; k < MAX_ORDER; k++) begin : g_cell
      hil2d_cell #(
         .LEVEL (k),
         .CW    (CW)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .order_eff (order_eff),
         .up_valid  (ch_valid[k]),
         .up_ready  (ch_ready[k]),
         .up_meta   (ch_meta[k]),
         .up_x      (ch_x[k]),
         .up_y      (ch_y[k]),
         .dn_valid  (ch_valid[k+1]),
         .dn_ready  (ch_ready[k+1]),
         .dn_meta   (ch_meta[k+1]),
         .dn_x      (ch_x[k+1]),
         .dn_y      (ch_y[k+1])
      );
   end

   hil2d_addr_stage #(
      .CW (CW)
   ) u_addr (
      .clock              (clock),
      .reset              (reset),
      .row_stride         (csr_row_stride_ff),
      .up_valid           (ch_valid[MAX_ORDER]),
      .up_ready           (ch_ready[MAX_ORDER]),
      .up_meta            (ch_meta[MAX_ORDER]),
      .up_x               (ch_x[MAX_ORDER]),
      .up_y               (ch_y[MAX_ORDER]),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_position_echo  (rsp_position_echo),
      .rsp_x_coord        (rsp_x_coord),
      .rsp_y_coord        (rsp_y_coord),
      .rsp_linear_address (rsp_linear_address),
      .rsp_out_of_range   (rsp_out_of_range)
   );

endmodule
